>>> rtl/alu_pkg.sv
package alu_pkg;

    typedef enum logic [4:0] {
        CMD_AND   = 5'd0,
        CMD_OR    = 5'd1,
        CMD_XOR   = 5'd2,
        CMD_NOT   = 5'd3,
        CMD_ASR   = 5'd4,
        CMD_LSR   = 5'd5,
        CMD_ROR   = 5'd6,
        CMD_ROL   = 5'd7,
        CMD_MUL   = 5'd8,
        CMD_MULU  = 5'd9,
        CMD_DIVU  = 5'd10,
        CMD_SUB   = 5'd11,
        CMD_SUBC  = 5'd12,
        CMD_ADD   = 5'd13,
        CMD_ADDC  = 5'd14,
        CMD_BSET  = 5'd15,
        CMD_BCLR  = 5'd16,
        CMD_ADDNF = 5'd17,
        CMD_EXT   = 5'd18
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Request to the shared shift-add/shift-subtract unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        signed_mul;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] hi;
    } mdu_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] prod;
        logic [31:0] quot;
        logic [15:0] rem;
    } mdu_rsp_t;

    localparam int unsigned STEPS = 16;

endpackage

>>> rtl/alu_mdu.sv
module alu_mdu
(
    input  logic              clk,
    input  logic              rst_n,
    input  alu_pkg::mdu_req_t req,
    output alu_pkg::mdu_rsp_t rsp
);
    import alu_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        div_reg, div_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] mcand_reg, mcand_next;
    logic [15:0] mplr_reg, mplr_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [32:0] trial;
    logic [31:0] ea, eb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        acc_reg   <= acc_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        dvs_reg   <= dvs_next;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        acc_next   = acc_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        dvs_next   = dvs_reg;
        ea = {{16{req.signed_mul & req.a[15]}}, req.a};
        eb = {{16{req.signed_mul & req.b[15]}}, req.b};
        trial = {rem_reg[31:0], quot_reg[31]} - {17'd0, dvs_reg};
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = '0;
            acc_next  = '0;
            if (req.is_div)
            begin
                quot_next = {req.hi, req.a};
                rem_next  = '0;
                dvs_next  = req.b;
            end
            else
            begin
                // Signed product mod 2^32: a*lowbits(b) minus a*b15<<16.
                mcand_next = ea;
                mplr_next  = eb[15:0];
                dvs_next   = {15'd0, req.signed_mul & req.b[15]};
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // One quotient bit is produced per cycle.
                if (!trial[32])
                begin
                    rem_next  = trial;
                    quot_next = {quot_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = {rem_reg[31:0], quot_reg[31]};
                    quot_next = {quot_reg[30:0], 1'b0};
                end
            end
            else
            begin
                if (mplr_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next = {mcand_reg[30:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[15:1]};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(div_reg ? 2 * STEPS - 1 : STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (!div_reg && dvs_reg[0])
                    acc_next = (mplr_reg[0] ? acc_reg + mcand_reg : acc_reg) -
                               {mcand_reg[30:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg[15:0];

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg))
        else $error("done without busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !busy_next |-> done_next)
        else $error("busy dropped without done");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("finish lost");

endmodule

>>> rtl/alu_with_flags_16_24bit.sv
// For all commands except mul, mulu and divu with a nonzero divisor, the input is
// registered in the idle state, then the result is computed and registered in the run
// state and offered in the done state; mul, mulu and divu with a nonzero divisor wait
// in the run state for the shared shift-add/shift-subtract unit. One item is in the
// block at a time; the next input transfer can follow in the cycle after the result
// transfer. rst_n clears flags, the multiply/divide register and all handshake state.
module alu_with_flags_16_24bit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[4:0], operand_dst[28:5], operand_src[52:29], mem_address[76:53],
    // mem_byte[84:77], zero fill [87:85]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[23:0], write_enable[24], write_address[48:25], flags_out[56:49],
    // muldiv_out[72:57], zero fill [79:73]
    output logic [79:0] m_axis_tdata
);
    import alu_pkg::*;

    state_t      state_reg, state_next;
    logic [87:0] in_reg, in_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] md_reg, md_next;
    logic [72:0] out_reg, out_next;
    mdu_req_t    req;
    mdu_rsp_t    rsp;

    logic [4:0]  cmd;
    logic [23:0] d, s, addr, r;
    logic [7:0]  mb, f;
    logic [15:0] md;
    logic        cin, we;
    logic [24:0] sum;
    logic [16:0] lo;
    logic        c16, c24, v16, v24, arith;

    assign cmd  = in_reg[4:0];
    assign d    = in_reg[28:5];
    assign s    = in_reg[52:29];
    assign addr = in_reg[76:53];
    assign mb   = in_reg[84:77];
    assign cin  = flags_reg[2];

    alu_mdu u_mdu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flags_reg <= '0;
            md_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flags_reg <= flags_next;
            md_reg    <= md_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        r = d;
        f = flags_reg;
        md = md_reg;
        we = 1'b0;
        arith = 1'b0;
        sum = '0;
        lo = '0;
        c16 = 1'b0;
        c24 = 1'b0;
        v16 = 1'b0;
        v24 = 1'b0;
        case (cmd)
            CMD_AND, CMD_OR, CMD_XOR, CMD_NOT, CMD_ASR, CMD_LSR, CMD_ROR, CMD_ROL:
            begin
                case (cmd)
                    CMD_AND: r = d & s;
                    CMD_OR:  r = d | s;
                    CMD_XOR: r = d ^ s;
                    CMD_NOT: r = d ^ 24'h00ffff;
                    CMD_ASR: r = {d[23:15], d[15:1]};
                    CMD_LSR: r = {d[23:16], 1'b0, d[15:1]};
                    CMD_ROR: r = {d[23:16], cin, d[15:1]};
                    default: r = {d[23:16], d[14:0], cin};
                endcase
                f[3:0] = {1'b0, (cmd == CMD_ROL) ? d[15] :
                          ((cmd >= CMD_ASR) ? d[0] : 1'b0), r[15], r[15:0] == 16'd0};
            end
            CMD_MUL, CMD_MULU:
            begin
                r = rsp.prod[23:0];
                md = rsp.prod[31:16];
                f[3] = 1'b0;
                f[1] = rsp.prod[15] | (cmd == CMD_MULU && rsp.prod[31]);
                f[0] = rsp.prod[15:0] == 16'd0;
            end
            CMD_DIVU:
            begin
                if (s[15:0] == 16'd0)
                begin
                    r = '0;
                    f[3] = 1'b1;
                end
                else
                begin
                    r = {8'd0, rsp.quot[15:0]};
                    md = rsp.rem;
                    if (rsp.quot[31:16] != 16'd0)
                        f[3] = 1'b1;
                    else
                        f = (flags_reg & 8'hc4) | {6'd0, rsp.quot[15],
                             rsp.quot[15:0] == 16'd0};
                end
            end
            CMD_SUB, CMD_SUBC:
            begin
                arith = 1'b1;
                sum = {1'b0, d} - {1'b0, s} - {24'd0, cmd == CMD_SUBC && cin};
                lo = {1'b0, d[15:0]} - {1'b0, s[15:0]} - {16'd0, cmd == CMD_SUBC && cin};
                c16 = lo[16];
                c24 = sum[24];
                v16 = (s[15] ^ d[15]) & (sum[15] ^ d[15]);
                v24 = (s[23] ^ d[23]) & (sum[23] ^ d[23]);
            end
            CMD_ADD, CMD_ADDC:
            begin
                arith = 1'b1;
                sum = {1'b0, d} + {1'b0, s} + {24'd0, cmd == CMD_ADDC && cin};
                lo = {1'b0, d[15:0]} + {1'b0, s[15:0]} + {16'd0, cmd == CMD_ADDC && cin};
                c16 = lo[16];
                c24 = sum[24];
                v16 = !(s[15] ^ d[15]) & (sum[15] ^ d[15]);
                v24 = !(s[23] ^ d[23]) & (sum[23] ^ d[23]);
            end
            CMD_BSET, CMD_BCLR:
            begin
                we = 1'b1;
                r = {16'd0, (cmd == CMD_BSET) ? (mb | s[7:0]) : (mb & ~s[7:0])};
                f[3:0] = {3'd0, (mb & s[7:0]) == 8'd0};
            end
            CMD_ADDNF: r = d + s;
            CMD_EXT:   md = {16{d[15]}};
            default: ;
        endcase
        if (arith)
        begin
            r = sum[23:0];
            f = {v24, c24, sum[23], sum[23:0] == 24'd0, v16, c16, sum[15],
                 sum[15:0] == 16'd0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_next    = in_reg;
        out_next   = out_reg;
        flags_next = flags_reg;
        md_next    = md_reg;
        req.start      = 1'b0;
        req.is_div     = cmd == CMD_DIVU;
        req.signed_mul = cmd == CMD_MUL;
        req.a          = d[15:0];
        req.b          = s[15:0];
        req.hi         = md_reg;
        s_axis_tready  = state_reg == ST_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_next = s_axis_tdata;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if ((cmd == CMD_MUL || cmd == CMD_MULU || cmd == CMD_DIVU) &&
                    !rsp.done)
                    req.start = !(cmd == CMD_DIVU && s[15:0] == 16'd0);
                if (!((cmd == CMD_MUL || cmd == CMD_MULU ||
                       (cmd == CMD_DIVU && s[15:0] != 16'd0)) && !rsp.done))
                begin
                    out_next = {md, f, we ? addr : 24'd0, we, r};
                    flags_next = f;
                    md_next = md;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = state_reg == ST_DONE;
    assign m_axis_tdata  = {7'd0, out_reg};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(out_reg))
        else $error("result changed while stalled");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("ready while result pending");
    a_flags_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |=> $stable(flags_reg) && $stable(md_reg))
        else $error("state changed while idle");

endmodule

>>> test/alu_flags_checker.sv
`timescale 1ns / 100ps

module alu_flags_checker
    import alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          op_count [0:31]
);

    typedef struct packed {
        logic [15:0] muldiv;
        logic [7:0]  flags;
        logic [23:0] waddr;
        logic        wen;
        logic [23:0] res;
    } alu_out_t;

    alu_out_t   expected_q[$];
    logic [7:0]  flag_reg;
    logic [15:0] md_reg;

    localparam logic [7:0] FZ = 8'h01, FN = 8'h02, FC = 8'h04, FV = 8'h08;

    assign pending_count = expected_q.size();

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic logic [7:0] arith_flags(logic [24:0] res, logic c16, logic c24,
                                               logic v16, logic v24);
        return {v24, c24, res[23], res[23:0] == 0, v16, c16, res[15], res[15:0] == 0};
    endfunction

    task automatic predict_op(input logic [87:0] d_in);
        logic [4:0]  cmd;
        logic [23:0] d, s, addr;
        logic [7:0]  mb;
        logic        cin;
        alu_out_t    o;
        logic [31:0] p, dividend, q;
        logic [24:0] sum;
        logic [16:0] lo;
        logic [15:0] dv;
        logic        c;
        cmd  = d_in[4:0];
        d    = d_in[28:5];
        s    = d_in[52:29];
        addr = d_in[76:53];
        mb   = d_in[84:77];
        cin  = flag_reg[2];
        o    = '0;
        o.res = d;
        op_count[cmd]++;
        case (cmd)
            CMD_AND, CMD_OR, CMD_XOR, CMD_NOT, CMD_ASR, CMD_LSR, CMD_ROR, CMD_ROL:
            begin
                c = 1'b0;
                case (cmd)
                    CMD_AND: o.res = d & s;
                    CMD_OR:  o.res = d | s;
                    CMD_XOR: o.res = d ^ s;
                    CMD_NOT: o.res = d ^ 24'h00ffff;
                    CMD_ASR: begin o.res = {d[23:15], d[15:1]}; c = d[0]; end
                    CMD_LSR: begin o.res = {d[23:16], 1'b0, d[15:1]}; c = d[0]; end
                    CMD_ROR: begin o.res = {d[23:16], cin, d[15:1]}; c = d[0]; end
                    default: begin o.res = {d[23:16], d[14:0], cin}; c = d[15]; end
                endcase
                flag_reg = (flag_reg & 8'hf0) | (o.res[15:0] == 0 ? FZ : 8'h0)
                           | (o.res[15] ? FN : 8'h0) | (c ? FC : 8'h0);
            end
            CMD_MUL, CMD_MULU: begin
                if (cmd == CMD_MUL)
                    p = $signed({{16{d[15]}}, d[15:0]}) * $signed({{16{s[15]}}, s[15:0]});
                else
                    p = {16'h0, d[15:0]} * {16'h0, s[15:0]};
                flag_reg = (flag_reg & 8'hf4) | (p[15:0] == 0 ? FZ : 8'h0)
                           | (p[15] ? FN : 8'h0);
                if (cmd == CMD_MULU && p[31]) flag_reg |= FN;
                md_reg = p[31:16];
                o.res  = p[23:0];
            end
            CMD_DIVU: begin
                dv = s[15:0];
                if (dv == 0) begin
                    flag_reg |= FV;
                    o.res = '0;
                end else begin
                    dividend = {md_reg, d[15:0]};
                    q = dividend / dv;
                    md_reg = 16'(dividend % dv);
                    if (q[31:16] != 0)
                        flag_reg |= FV;
                    else
                        flag_reg = (flag_reg & 8'hc4) | (q[15] ? FN : 8'h0)
                                   | (q == 0 ? FZ : 8'h0);
                    o.res = {8'h0, q[15:0]};
                end
            end
            CMD_SUB, CMD_SUBC: begin
                c = (cmd == CMD_SUBC) ? cin : 1'b0;
                sum = {1'b0, d} - {1'b0, s} - c;
                o.res = sum[23:0];
                flag_reg = arith_flags(sum,
                    ({1'b0, s[15:0]} + c) > {1'b0, d[15:0]},
                    ({1'b0, s} + c) > {1'b0, d},
                    (s[15] ^ d[15]) && (o.res[15] ^ d[15]),
                    (s[23] ^ d[23]) && (o.res[23] ^ d[23]));
            end
            CMD_ADD, CMD_ADDC: begin
                c = (cmd == CMD_ADDC) ? cin : 1'b0;
                sum = {1'b0, d} + {1'b0, s} + c;
                lo  = {1'b0, d[15:0]} + {1'b0, s[15:0]} + c;
                o.res = sum[23:0];
                flag_reg = arith_flags(sum, lo[16], sum[24],
                    !(s[15] ^ d[15]) && (o.res[15] ^ d[15]),
                    !(s[23] ^ d[23]) && (o.res[23] ^ d[23]));
            end
            CMD_BSET, CMD_BCLR: begin
                flag_reg = (flag_reg & 8'hf0) | ((mb & s[7:0]) == 0 ? FZ : 8'h0);
                o.res = (cmd == CMD_BSET) ? {16'h0, mb | s[7:0]} : {16'h0, mb & ~s[7:0]};
                o.wen = 1'b1;
                o.waddr = addr;
            end
            CMD_ADDNF: o.res = d + s;
            CMD_EXT:   md_reg = d[15] ? 16'hffff : 16'h0;
            default: ;
        endcase
        o.flags  = flag_reg;
        o.muldiv = md_reg;
        expected_q.push_back(o);
    endtask

    always @(posedge clk or negedge rst_n) begin
        alu_out_t got, want;
        if (!rst_n) begin
            flag_reg = '0;
            md_reg   = '0;
            expected_q.delete();
            fail_count = 0;
            foreach (op_count[i]) op_count[i] = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_op(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[72:0];
                if (expected_q.size() == 0) begin
                    $display("unexpected transfer at %0t", $time);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.res != want.res) report_mismatch("result", got.res, want.res);
                    if (got.wen != want.wen) report_mismatch("write_enable", got.wen, want.wen);
                    if (got.waddr != want.waddr)
                        report_mismatch("write_address", got.waddr, want.waddr);
                    if (got.flags != want.flags) report_mismatch("flags", got.flags, want.flags);
                    if (got.muldiv != want.muldiv)
                        report_mismatch("muldiv", got.muldiv, want.muldiv);
                end
            end
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import alu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          op_count [0:31];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    localparam int QUIET_LIMIT = 20000;

    alu_with_flags_16_24bit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    alu_flags_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count), .op_count(op_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[alu_with_flags_16_24bit] ERROR");
            $finish;
        end
    end

    function automatic logic [23:0] pick_operand();
        case ($urandom_range(7))
            0: return 24'h000000;
            1: return 24'hffffff;
            2: return {8'($urandom), 16'h8000};
            3: return {8'($urandom), 16'h7fff};
            4: return {8'($urandom), 16'($urandom_range(3))};
            5: return 24'($urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_op(input logic [4:0] cmd, input logic [23:0] d, input logic [23:0] s,
                           input logic [23:0] addr, input logic [7:0] mb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, mb, addr, s, d, cmd};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random();
        logic [4:0] cmd;
        cmd = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18));
        send_op(cmd, pick_operand(), pick_operand(), 24'($urandom), 8'($urandom));
    endtask

    initial begin
        int n_ops;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 46;
        quiet_cycles  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(CMD_ADD, 24'hffffff, 24'h000001, 24'h0, 8'h00);
        send_op(CMD_ADDC, 24'h7fffff, 24'h000000, 24'h0, 8'h00);
        send_op(CMD_ADD, 24'h007fff, 24'h000001, 24'h0, 8'h00);
        send_op(CMD_SUB, 24'h000000, 24'h000001, 24'h0, 8'h00);
        send_op(CMD_SUBC, 24'h800000, 24'h000000, 24'h0, 8'h00);
        send_op(CMD_ROR, 24'h000001, 24'h0, 24'h0, 8'h00);
        send_op(CMD_ROL, 24'hff8000, 24'h0, 24'h0, 8'h00);
        send_op(CMD_ASR, 24'h00ffff, 24'h0, 24'h0, 8'h00);
        send_op(CMD_LSR, 24'hffffff, 24'h0, 24'h0, 8'h00);
        send_op(CMD_AND, 24'hffffff, 24'h000000, 24'h0, 8'h00);
        send_op(CMD_OR, 24'h000000, 24'hffffff, 24'h0, 8'h00);
        send_op(CMD_XOR, 24'hffffff, 24'hffffff, 24'h0, 8'h00);
        send_op(CMD_NOT, 24'h123456, 24'h0, 24'h0, 8'h00);
        send_op(CMD_MUL, 24'h008000, 24'h008000, 24'h0, 8'h00);
        send_op(CMD_MULU, 24'hffffff, 24'hffffff, 24'h0, 8'h00);
        send_op(CMD_DIVU, 24'h001234, 24'h000000, 24'h0, 8'h00);
        send_op(CMD_DIVU, 24'h00ffff, 24'h000001, 24'h0, 8'h00);
        send_op(CMD_EXT, 24'h000000, 24'h0, 24'h0, 8'h00);
        send_op(CMD_DIVU, 24'h000000, 24'h000007, 24'h0, 8'h00);
        send_op(CMD_EXT, 24'h008000, 24'h0, 24'h0, 8'h00);
        send_op(CMD_DIVU, 24'h000005, 24'h000003, 24'h0, 8'h00);
        send_op(CMD_BSET, 24'h0, 24'hffff80, 24'hffffff, 8'h7f);
        send_op(CMD_BCLR, 24'h0, 24'h0000ff, 24'h000000, 8'hff);
        send_op(CMD_ADDNF, 24'hffffff, 24'hffffff, 24'h0, 8'h00);
        send_op(5'd31, 24'habcdef, 24'h0, 24'h0, 8'h00);

        n_ops = 25;
        for (int i = 0; i < 1800; i++) begin
            if (i == 600) begin
                send_idle_pct = 46;
                recv_idle_pct = 22;
            end else if (i == 1200) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random();
            n_ops++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d operations over all commands; mul %0d, divu %0d, bit ops %0d.",
                 n_ops, op_count[CMD_MUL] + op_count[CMD_MULU], op_count[CMD_DIVU],
                 op_count[CMD_BSET] + op_count[CMD_BCLR]);
        if (fail_count == 0 && pending_count == 0)
            $display("[alu_with_flags_16_24bit] OK");
        else
            $display("[alu_with_flags_16_24bit] ERROR");
        $finish;
    end

endmodule
